// File: sv/sppk_pkg.sv
// Shared types and constants for the spectrum top-three peak picker.
// Used by sppk_cell and spectrum_top3_peak_picker; depends on nothing.
package sppk_pkg;

  localparam int unsigned MaxBinsDefault = 512;
  localparam int unsigned BinW           = 9;
  localparam int unsigned ValW           = 31;
  localparam int unsigned SampleW        = 32;
  localparam int unsigned NumPeaks       = 3;
  localparam logic [BinW-1:0] SkipReset  = 9'd64;

  // One entry of the sorted peak list.
  typedef struct packed {
    logic [ValW-1:0] value;
    logic [BinW-1:0] bin;
  } pair_t;

  // What a cell hands to the next cell down the list.
  typedef struct packed {
    logic  gt;
    pair_t pair;
  } link_t;

endpackage

// File: sv/spectrum_top3_peak_picker.sv
// The result beat is registered and appears in the cycle after the beat carrying tlast is taken.
// Throughput: one bin per cycle; the bin window and a row of three list cells all
// update in the cycle a beat is taken, so no beat waits on the one before it.
// A new frame-end beat waits only while an earlier result beat is still unread.
// Reset (rst_n low, synchronous) clears the window, the bin counter and the list,
// and sets low_bin_skip to 64.
module spectrum_top3_peak_picker #(
  parameter int unsigned MAX_BINS = sppk_pkg::MaxBinsDefault
) (
  input  logic          clk,
  input  logic          rst_n,
  // cfg_data: low_bin_skip [8:0]
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [8:0]    cfg_data,
  // in_tdata: bin_value [31:0]
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [31:0]   in_tdata,
  input  logic          in_tlast,
  // out_tdata: first_peak_value [30:0], first_peak_bin [39:31],
  //            second_peak_value [70:40], second_peak_bin [79:71],
  //            third_peak_value [110:80], third_peak_bin [119:111]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [119:0]  out_tdata
);

  localparam int unsigned CNT_W = $clog2(MAX_BINS);
  localparam int unsigned CMP_W = (CNT_W > sppk_pkg::BinW) ? CNT_W : sppk_pkg::BinW;
  localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_BINS - 1);

  logic [sppk_pkg::BinW-1:0]           skip_r;
  logic signed [sppk_pkg::SampleW-1:0] older_r;
  logic signed [sppk_pkg::SampleW-1:0] middle_r;
  logic [CNT_W-1:0]                    cnt_r;
  logic [CNT_W-1:0]                    cnt_nxt;
  logic                                out_valid_r;
  logic [119:0]                        out_data_r;

  logic                                accept;
  logic                                frame_end;
  logic signed [sppk_pkg::SampleW-1:0] cur;
  logic [CMP_W-1:0]                    mid_idx;
  logic                                cand_valid;
  sppk_pkg::pair_t                     cand;
  sppk_pkg::link_t                     links [sppk_pkg::NumPeaks+1];
  sppk_pkg::pair_t                     ins   [sppk_pkg::NumPeaks];

  assign cfg_ready = 1'b1;

  // Only a frame-end beat needs room in the output register.
  assign in_tready = out_tready || !out_valid_r || !in_tlast;
  assign accept    = in_tvalid && in_tready;
  assign frame_end = accept && in_tlast;
  assign cur       = $signed(in_tdata);

  // The middle bin is judged against its older and incoming neighbours.
  // A negative middle bin can never beat a list entry, which starts at zero.
  assign mid_idx    = CMP_W'(cnt_r) - CMP_W'(1);
  assign cand_valid = (cnt_r != '0) && (mid_idx > CMP_W'(skip_r)) &&
                      (middle_r > older_r) && (middle_r > cur) && !middle_r[31];
  assign cand.value = middle_r[sppk_pkg::ValW-1:0];
  assign cand.bin   = mid_idx[sppk_pkg::BinW-1:0];

  assign links[0] = '0;

  for (genvar k = 0; k < sppk_pkg::NumPeaks; k++) begin : g_cell
    sppk_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .load       (accept),
      .clear      (frame_end),
      .cand_valid (cand_valid),
      .cand       (cand),
      .up_link    (links[k]),
      .down_link  (links[k+1]),
      .pair_ins   (ins[k])
    );
  end

  assign cnt_nxt = (cnt_r != CntMax) ? cnt_r + CNT_W'(1) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r   <= sppk_pkg::SkipReset;
      older_r  <= '0;
      middle_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        skip_r <= cfg_data;
      end
      if (frame_end) begin
        older_r  <= '0;
        middle_r <= '0;
        cnt_r    <= '0;
      end else if (accept) begin
        older_r  <= middle_r;
        middle_r <= cur;
        cnt_r    <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (frame_end) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_end) begin
      out_data_r <= {ins[2].bin, ins[2].value,
                     ins[1].bin, ins[1].value,
                     ins[0].bin, ins[0].value};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: sv/sppk_cell.sv
// One slot of the sorted top-three list: holds a (value, bin) pair.
// Depends on sppk_pkg for pair_t and link_t.
module sppk_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  logic            clear,
  input  logic            cand_valid,
  input  sppk_pkg::pair_t cand,
  input  sppk_pkg::link_t up_link,
  output sppk_pkg::link_t down_link,
  output sppk_pkg::pair_t pair_ins
);

  sppk_pkg::pair_t pair_r;
  sppk_pkg::pair_t pair_nxt;
  logic            gt;

  assign gt = cand_valid && (cand.value > pair_r.value);

  // A slot above that took the candidate pushes its old pair into this one.
  always_comb begin
    if (up_link.gt) begin
      pair_ins = up_link.pair;
    end else if (gt) begin
      pair_ins = cand;
    end else begin
      pair_ins = pair_r;
    end
  end

  always_comb begin
    if (clear) begin
      pair_nxt = '0;
    end else if (load) begin
      pair_nxt = pair_ins;
    end else begin
      pair_nxt = pair_r;
    end
  end

  assign down_link.gt   = gt;
  assign down_link.pair = pair_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_r <= '0;
    end else begin
      pair_r <= pair_nxt;
    end
  end

endmodule

// File: sim/spectrum_top3_peak_picker_tb.sv
// Self-checking testbench for spectrum_top3_peak_picker: streams spectrum frames under
// random source gaps and sink stalls and checks every result beat against a predictor.
// Depends on sppk_pkg and the spectrum_top3_peak_picker RTL only.
module spectrum_top3_peak_picker_tb;

  localparam int CycleLimit = 200000;
  localparam logic [8:0] SkipMax = 9'd511;
  localparam int unsigned CountTop = sppk_pkg::MaxBinsDefault - 1;

  typedef sppk_pkg::pair_t [sppk_pkg::NumPeaks-1:0] peak_list_t;

  // Predicts the top-three list at each frame end and checks the result beats.
  class peak_board;
    logic [8:0] skip;
    logic signed [31:0] older;
    logic signed [31:0] middle;
    int unsigned count;
    sppk_pkg::pair_t list [sppk_pkg::NumPeaks];
    peak_list_t frame_results[$];
    int errors;

    function new();
      errors = 0;
      skip = sppk_pkg::SkipReset;
      clear_frame();
    endfunction

    function void clear_frame();
      older = '0;
      middle = '0;
      count = 0;
      for (int k = 0; k < sppk_pkg::NumPeaks; k++) list[k] = '0;
    endfunction

    function int pending();
      return frame_results.size();
    endfunction

    function void note_bin(logic [31:0] raw, logic last);
      logic signed [31:0] cur;
      int unsigned mid_idx;
      int pos;
      peak_list_t e;
      cur = raw;
      // The middle bin is judged now that its right neighbour has arrived.
      if (count >= 1) begin
        mid_idx = count - 1;
        if (mid_idx > skip && middle > older && middle > cur) begin
          pos = sppk_pkg::NumPeaks;
          for (int k = sppk_pkg::NumPeaks - 1; k >= 0; k--)
            if (longint'(middle) > longint'(list[k].value)) pos = k;
          if (pos < sppk_pkg::NumPeaks) begin
            for (int k = sppk_pkg::NumPeaks - 1; k > pos; k--) list[k] = list[k-1];
            list[pos].value = middle[sppk_pkg::ValW-1:0];
            list[pos].bin = 9'(mid_idx);
          end
        end
      end
      if (last) begin
        for (int k = 0; k < sppk_pkg::NumPeaks; k++) e[k] = list[k];
        frame_results.push_back(e);
        clear_frame();
      end else begin
        older = middle;
        middle = cur;
        if (count < CountTop) count++;
      end
    endfunction

    function void check_result(logic [119:0] d);
      peak_list_t e;
      logic [sppk_pkg::ValW-1:0] got_value;
      logic [sppk_pkg::BinW-1:0] got_bin;
      if (frame_results.size() == 0) begin
        $display("%0t: result beat with no frame end pending, got %h", $time, d);
        errors++;
        return;
      end
      e = frame_results.pop_front();
      for (int k = 0; k < sppk_pkg::NumPeaks; k++) begin
        got_value = d[k*40 +: sppk_pkg::ValW];
        got_bin = d[k*40+sppk_pkg::ValW +: sppk_pkg::BinW];
        if (got_value !== e[k].value) begin
          $display("%0t: peak %0d value expected %h, got %h", $time, k, e[k].value,
                   got_value);
          errors++;
        end
        if (got_bin !== e[k].bin) begin
          $display("%0t: peak %0d bin expected %0d, got %0d", $time, k, e[k].bin, got_bin);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [8:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [119:0] out_tdata;

  peak_board board = new();
  int burst_left = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  int cycles = 0;

  spectrum_top3_peak_picker DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Both channels are sampled before the edge's nonblocking updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_bin(in_tdata, in_tlast);
      if (out_tvalid && out_tready) board.check_result(out_tdata);
    end
  end

  // Sink: a stall mode that is redrawn at random on a tick counter, plus one long hold-off on request.
  initial begin
    int hold_left;
    int mode;
    int tick;
    bit hold_done;
    hold_left = 0;
    mode = 0;
    tick = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (tick % 80 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= tick[0];
        endcase
      end
      tick++;
    end
  end

  function automatic logic [31:0] pick_bin_value(int style);
    case (style)
      0: return 32'($urandom_range(0, 7));
      1: return $urandom();
      2: return $urandom() & 32'h7FFF_FFFF;
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return 32'($urandom_range(0, 16)) - 32'd8;
    endcase
  endfunction

  // The source sends in bursts; each burst starts after a short gap unless steady is set.
  task automatic send_bin(input logic [31:0] value, input logic last);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? 120 : $urandom_range(1, 16);
      if (!steady) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= value;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_frame(input int len, input int style);
    for (int i = 0; i < len; i++) send_bin(pick_bin_value(style), i == len - 1);
  endtask

  task automatic random_frames(input int total, input int max_len);
    int sent;
    int len;
    sent = 0;
    while (sent < total) begin
      len = $urandom_range(1, max_len);
      send_frame(len, $urandom_range(0, 4));
      sent += len;
    end
  endtask

  // Lets every frame result drain so the block is idle before a register write.
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_skip(input logic [8:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.skip = value;
  endtask

  initial begin
    // Extreme values, a tie that is not a peak, a negative local maximum and a
    // high last bin that is never judged.
    logic [31:0] directed_bins [17];
    directed_bins = '{
      32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd5, 32'd5, 32'd4, 32'd0,
      32'd9, 32'd3, 32'd10, 32'd2, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'hFFFF_0000,
      32'd1, 32'd0, 32'h7FFF_FFFF
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A frame whose first bin is also its last gives an all-zero result.
    send_bin(32'h7FFF_FFFF, 1'b1);
    settle();
    write_skip(9'd0);
    for (int i = 0; i < 17; i++) send_bin(directed_bins[i], i == 16);
    send_bin(32'd3, 1'b0);
    send_bin(32'd1, 1'b1);

    random_frames(150, 24);
    settle();
    write_skip(9'($urandom_range(0, 7)));
    random_frames(150, 24);

    // Tiny back-to-back frames while the sink holds off, so the input backs up.
    settle();
    write_skip(9'd0);
    steady = 1'b1;
    hold_req = 1'b1;
    random_frames(60, 3);
    steady = 1'b0;

    settle();
    write_skip(SkipMax);
    random_frames(50, 20);

    // One frame past the counter's saturation point, with candidates near the top.
    settle();
    write_skip(9'd505);
    send_frame(520, 0);

    settle();
    write_skip(sppk_pkg::SkipReset);
    random_frames(100, 100);

    settle();
    write_skip(9'($urandom_range(0, 15)));
    random_frames(150, 30);

    settle();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
